// ----- rtl/core/rgb_to_display_pixel_converter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the display pixel converter
// Clocked on i_clk, switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_DISPLAY_PIXEL_CONVERTER_MACROS_SVH
`define RGB_TO_DISPLAY_PIXEL_CONVERTER_MACROS_SVH

// same-cycle implication
`define RDPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdpc_pkg
// Types, codes and helpers shared by the display pixel converter.
// ----------------------------------------------------------------------------
package rdpc_pkg;

    localparam int unsigned MASK_W = 32;

    localparam logic [MASK_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [MASK_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [MASK_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_BUILD   = 2'd1,
        ACT_CONVERT = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_RED   = 2'd1,
        CFG_GREEN = 2'd2,
        CFG_BLUE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_BUILD
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [7:0]  entry_index;
        logic [15:0] entry_red;
        logic [15:0] entry_green;
        logic [15:0] entry_blue;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        is_pixel;
    } t_out_word;

    typedef struct packed {
        logic              we;
        t_cfg_idx          idx;
        logic [MASK_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic        we;
        logic [7:0]  addr;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pal_wr;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic [4:0] lsh;
        logic [3:0] rsh;
    } t_shift;

    // lowest set bit gives the left shift; run of ones above it gives the right shift
    function automatic t_shift mask_shift(input logic [MASK_W-1:0] m);
        logic [4:0]        l;
        logic [MASK_W-1:0] t;
        logic [3:0]        run;
        t_shift            s;
        l = '0;
        for (int k = MASK_W - 1; k >= 0; k--) begin
            if (m[k]) l = 5'(k);
        end
        t   = m >> l;
        run = 4'd8;
        for (int k = 7; k >= 0; k--) begin
            if (!t[k]) run = 4'(k);
        end
        s.lsh = l;
        s.rsh = 4'd8 - run;
        return s;
    endfunction

    localparam t_shift RED_SH_RST   = mask_shift(RED_MASK_RST);
    localparam t_shift GREEN_SH_RST = mask_shift(GREEN_MASK_RST);
    localparam t_shift BLUE_SH_RST  = mask_shift(BLUE_MASK_RST);

endpackage

// ----- rtl/core/rdpc_mask.sv -----
// ----------------------------------------------------------------------------
// rdpc_mask
// Channel mask registers and truecolor packing of one pixel.
// ----------------------------------------------------------------------------
module rdpc_mask
    import rdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    output logic [MASK_W-1:0] o_pixel
);

    logic [MASK_W-1:0] r_red_mask, r_green_mask, r_blue_mask;
    t_shift            r_red_sh, r_green_sh, r_blue_sh;

    function automatic logic [MASK_W-1:0] pack_ch(input logic [7:0] v,
                                                  input logic [MASK_W-1:0] m,
                                                  input t_shift s);
        logic [MASK_W-1:0] x;
        x = {24'b0, v >> s.rsh} << s.lsh;
        return x & m;
    endfunction

    // shift amounts are worked out when the mask is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_mask   <= RED_MASK_RST;
            r_green_mask <= GREEN_MASK_RST;
            r_blue_mask  <= BLUE_MASK_RST;
            r_red_sh     <= RED_SH_RST;
            r_green_sh   <= GREEN_SH_RST;
            r_blue_sh    <= BLUE_SH_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_RED: begin
                    r_red_mask <= i_cfg.data;
                    r_red_sh   <= mask_shift(i_cfg.data);
                end
                CFG_GREEN: begin
                    r_green_mask <= i_cfg.data;
                    r_green_sh   <= mask_shift(i_cfg.data);
                end
                CFG_BLUE: begin
                    r_blue_mask <= i_cfg.data;
                    r_blue_sh   <= mask_shift(i_cfg.data);
                end
                default: ;
            endcase
        end
    end

    assign o_pixel = pack_ch(i_red, r_red_mask, r_red_sh)
                   | pack_ch(i_green, r_green_mask, r_green_sh)
                   | pack_ch(i_blue, r_blue_mask, r_blue_sh);

endmodule

// ----- rtl/core/rdpc_build.sv -----
// ----------------------------------------------------------------------------
// rdpc_build
// Palette memory and the pipelined nearest-colour search that fills the table.
// ----------------------------------------------------------------------------
`include "rgb_to_display_pixel_converter_macros.svh"

module rdpc_build
    import rdpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pal_wr i_pal_wr,
    input  logic    i_start,
    output t_tbl_wr o_tbl_wr,
    output logic    o_done
);

    logic [47:0] mem [256];
    logic [47:0] r_pal_q;

    logic       r_run;
    logic [7:0] r_i, r_j;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [7:0]  r_i1, r_j1, r_i2, r_j2, r_i3, r_j3, r_i4, r_j4;
    logic [15:0] r_dr, r_dg, r_db;
    logic [31:0] r_sr, r_sg, r_sb;
    logic [33:0] r_sum;
    logic [33:0] r_best;
    logic [7:0]  r_best_j;
    logic        r_tw_we;
    logic [7:0]  r_tw_addr, r_tw_data;
    logic        r_done;

    logic [15:0] w_tr, w_tg, w_tb;
    logic        w_take;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // palette: one write port (write action), one read port (search)
    always_ff @(posedge i_clk) begin
        if (i_pal_wr.we) begin
            mem[i_pal_wr.addr] <= {i_pal_wr.red, i_pal_wr.green, i_pal_wr.blue};
        end
        r_pal_q <= mem[r_j];
    end

    // sweep: target index i outer, palette index j inner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_i   <= '0;
            r_j   <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_i   <= '0;
            r_j   <= '0;
        end else if (r_run) begin
            r_j <= r_j + 8'd1;
            if (r_j == 8'hFF) begin
                r_i <= r_i + 8'd1;
                if (r_i == 8'hFF) r_run <= 1'b0;
            end
        end
    end

    assign w_tr = {r_i1[7:5], 13'b0};
    assign w_tg = {r_i1[4:2], 13'b0};
    assign w_tb = {r_i1[1:0], 14'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= r_run;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= r_i;
        r_j1  <= r_j;
        r_dr  <= abs_diff(r_pal_q[47:32], w_tr);
        r_dg  <= abs_diff(r_pal_q[31:16], w_tg);
        r_db  <= abs_diff(r_pal_q[15:0], w_tb);
        r_i2  <= r_i1;
        r_j2  <= r_j1;
        r_sr  <= r_dr * r_dr;
        r_sg  <= r_dg * r_dg;
        r_sb  <= r_db * r_db;
        r_i3  <= r_i2;
        r_j3  <= r_j2;
        r_sum <= {2'b0, r_sr} + {2'b0, r_sg} + {2'b0, r_sb};
        r_i4  <= r_i3;
        r_j4  <= r_j3;
    end

    // ties go to the later entry
    assign w_take = (r_j4 == 8'h00) || (r_sum <= r_best);

    always_ff @(posedge i_clk) begin
        if (r_v4 && w_take) begin
            r_best   <= r_sum;
            r_best_j <= r_j4;
        end
        r_tw_addr <= r_i4;
        r_tw_data <= w_take ? r_j4 : r_best_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw_we <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_tw_we <= r_v4 && (r_j4 == 8'hFF);
            r_done  <= r_tw_we && (r_tw_addr == 8'hFF);
        end
    end

    assign o_tbl_wr.we   = r_tw_we;
    assign o_tbl_wr.addr = r_tw_addr;
    assign o_tbl_wr.data = r_tw_data;
    assign o_done        = r_done;

    `RDPC_ASSERT_SAME(a_start_when_empty, i_start,
        !r_run && !r_v1 && !r_v2 && !r_v3 && !r_v4, "build started while searching")
    `RDPC_ASSERT_NEXT(a_tbl_wr_spaced, r_tw_we, !r_tw_we, "table writes too close")
    `RDPC_ASSERT_SAME(a_done_drained, r_done, !r_run && !r_v4 && !r_tw_we,
        "build done before pipeline drained")

endmodule

// ----- rtl/core/rdpc_lut.sv -----
// ----------------------------------------------------------------------------
// rdpc_lut
// Nearest-colour table: written by the build, read by palette conversion.
// ----------------------------------------------------------------------------
module rdpc_lut
    import rdpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tbl_wr    i_wr,
    input  logic       i_re,
    input  logic [7:0] i_raddr,
    output logic [7:0] o_q
);

    logic [7:0] mem [256];
    logic [7:0] r_q;
    logic       r_built;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) mem[i_wr.addr] <= i_wr.data;
        if (i_re)    r_q <= mem[i_raddr];
    end

    // a build always writes every word, so one flag stands for the whole table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built <= 1'b0;
        end else if (i_wr.we) begin
            r_built <= 1'b1;
        end
    end

    assign o_q = r_built ? r_q : 8'h00;

endmodule

// ----- rtl/core/rgb_to_display_pixel_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_display_pixel_converter
// RGB888 to truecolour pixel or nearest palette index, with table build.
// ----------------------------------------------------------------------------
// Write, unused and truecolour words: result one cycle after accept, one per cycle.
// Palette convert: result through the table read register, then the output register; busy for one cycle.
// Build: 256 x 256 distance pipeline, one compare per cycle.
// Reset is synchronous: masks to defaults, mode truecolour, table reads as zero.
// Palette memory holds no reset value; the receiver cannot stall results.
`include "rgb_to_display_pixel_converter_macros.svh"

module rgb_to_display_pixel_converter
    import rdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_in_word          i_in,
    output logic              o_done,
    output t_out_word         o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [MASK_W-1:0] i_cfg_data
);

    t_state     r_state, n_state;
    logic       r_mode;
    logic       r_done, n_done;
    t_out_word  r_out, n_out;

    logic              w_accept;
    t_cfg_wr           w_cfg;
    t_pal_wr           w_pal_wr;
    logic              w_pal_we;
    logic              w_build_start;
    logic              w_build_done;
    t_tbl_wr           w_tbl_wr;
    logic              w_lut_re;
    logic [7:0]        w_lut_addr;
    logic [7:0]        w_lut_q;
    logic [MASK_W-1:0] w_true_pixel;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.we    = i_cfg_valid;
    assign w_cfg.idx   = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign o_busy   = (r_state != ST_IDLE);
    assign w_accept = i_start && !o_busy;

    assign w_lut_addr = {i_in.pixel_red[7:5], i_in.pixel_green[7:5], i_in.pixel_blue[7:6]};

    assign w_pal_wr.we    = w_pal_we;
    assign w_pal_wr.addr  = i_in.entry_index;
    assign w_pal_wr.red   = i_in.entry_red;
    assign w_pal_wr.green = i_in.entry_green;
    assign w_pal_wr.blue  = i_in.entry_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (w_cfg.we && (w_cfg.idx == CFG_MODE)) begin
            r_mode <= w_cfg.data[0];
        end
    end

    rdpc_mask u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_red   (i_in.pixel_red),
        .i_green (i_in.pixel_green),
        .i_blue  (i_in.pixel_blue),
        .o_pixel (w_true_pixel)
    );

    rdpc_build u_build (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pal_wr (w_pal_wr),
        .i_start  (w_build_start),
        .o_tbl_wr (w_tbl_wr),
        .o_done   (w_build_done)
    );

    rdpc_lut u_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_tbl_wr),
        .i_re    (w_lut_re),
        .i_raddr (w_lut_addr),
        .o_q     (w_lut_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.action == ACT_BUILD) begin
                        n_state = ST_BUILD;
                    end else if ((i_in.action == ACT_CONVERT) && r_mode) begin
                        n_state = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: n_state = ST_IDLE;
            ST_BUILD: begin
                if (w_build_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_pal_we      = 1'b0;
        w_build_start = 1'b0;
        w_lut_re      = 1'b0;
        n_done        = 1'b0;
        n_out         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.action)
                        ACT_WRITE: begin
                            w_pal_we = 1'b1;
                            n_done   = 1'b1;
                        end
                        ACT_BUILD: w_build_start = 1'b1;
                        ACT_CONVERT: begin
                            if (r_mode) begin
                                w_lut_re = 1'b1;
                            end else begin
                                n_done            = 1'b1;
                                n_out.pixel_value = w_true_pixel;
                                n_out.is_pixel    = 1'b1;
                            end
                        end
                        ACT_NONE: n_done = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                n_done            = 1'b1;
                n_out.pixel_value = {24'b0, w_lut_q};
                n_out.is_pixel    = 1'b1;
            end
            ST_BUILD: begin
                if (w_build_done) n_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    `RDPC_ASSERT_NEXT(a_lookup_returns, r_state == ST_LOOKUP,
        r_done && r_out.is_pixel && (r_state == ST_IDLE), "palette word not returned")
    `RDPC_ASSERT_NEXT(a_quick_word, w_accept && (i_in.action != ACT_BUILD) &&
        !((i_in.action == ACT_CONVERT) && r_mode), r_done, "word result missing")
    `RDPC_ASSERT_SAME(a_build_quiet, (r_state == ST_BUILD) && !w_build_done,
        !n_done && !w_pal_we, "result or palette write during build")

endmodule

// ----- tb/rgb_to_display_pixel_converter_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_to_display_pixel_converter_tb
// Self-checking bench for the display pixel converter. A short directed run
// covers the mask extremes, the unused action and palette lookups before any
// build. The palette is then filled with targets, duplicates and noise, the
// nearest table is built, and random rounds mix conversions, palette writes,
// unused actions and occasional rebuilds under changing mode and masks. Every
// result is checked against a typed value or an in-bench model of the converter.
// ----------------------------------------------------------------------------
module rgb_to_display_pixel_converter_tb;
    import rdpc_pkg::*;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_start     = 1'b0;
    t_in_word          i_in        = '0;
    logic              i_cfg_valid = 1'b0;
    t_cfg_idx          i_cfg_index = CFG_MODE;
    logic [MASK_W-1:0] i_cfg_data  = '0;
    logic              o_busy;
    logic              o_done;
    logic              o_cfg_ready;
    t_out_word         o_out;

    rgb_to_display_pixel_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // converter model state
    logic        mode_pal;
    logic [31:0] red_bits, green_bits, blue_bits;
    logic [15:0] pal_red [256];
    logic [15:0] pal_grn [256];
    logic [15:0] pal_blu [256];
    logic [7:0]  nearest [256];

    t_out_word pending_words [$];
    t_out_word mon_want;
    int        errors    = 0;
    int        n_results = 0;
    int        n_regs    = 0;
    int        n_act [4] = '{0, 0, 0, 0};
    bit        no_gaps   = 1'b0;

    typedef struct {
        bit          is_reg;
        t_cfg_idx    idx;
        logic [31:0] data;
        t_in_word    word;
        bit          typed;
        t_out_word   want;
    } t_dir_row;

    t_dir_row dir_rows [$];

    function automatic logic [31:0] channel_field(logic [7:0] v, logic [31:0] m);
        int          lsh;
        int          run;
        int          rsh;
        logic [63:0] x;
        lsh = 0;
        run = 0;
        if (m != 0) begin
            while (!m[lsh]) lsh++;
            while (lsh + run < 32 && m[lsh + run]) run++;
        end
        rsh = (run > 8) ? 0 : 8 - run;
        x   = (64'(v) >> rsh) << lsh;
        return x[31:0] & m;
    endfunction

    function automatic void rebuild_nearest();
        logic [7:0]  iv;
        logic [15:0] tr, tg, tb;
        logic [63:0] dr, dg, db, d, best;
        int          pick;
        for (int i = 0; i < 256; i++) begin
            iv   = 8'(i);
            tr   = {iv[7:5], 13'b0};
            tg   = {iv[4:2], 13'b0};
            tb   = {iv[1:0], 14'b0};
            best = '0;
            pick = 0;
            for (int j = 0; j < 256; j++) begin
                dr = (pal_red[j] > tr) ? 64'(pal_red[j] - tr) : 64'(tr - pal_red[j]);
                dg = (pal_grn[j] > tg) ? 64'(pal_grn[j] - tg) : 64'(tg - pal_grn[j]);
                db = (pal_blu[j] > tb) ? 64'(pal_blu[j] - tb) : 64'(tb - pal_blu[j]);
                d  = dr * dr + dg * dg + db * db;
                // ties go to the later entry
                if (j == 0 || d <= best) begin
                    best = d;
                    pick = j;
                end
            end
            nearest[i] = 8'(pick);
        end
    endfunction

    function automatic t_out_word convert_word(t_in_word w);
        t_out_word o;
        o = '0;
        case (w.action)
            ACT_WRITE: begin
                pal_red[w.entry_index] = w.entry_red;
                pal_grn[w.entry_index] = w.entry_green;
                pal_blu[w.entry_index] = w.entry_blue;
            end
            ACT_BUILD: rebuild_nearest();
            ACT_CONVERT: begin
                o.is_pixel = 1'b1;
                if (!mode_pal) begin
                    o.pixel_value = channel_field(w.pixel_red, red_bits)
                                  | channel_field(w.pixel_green, green_bits)
                                  | channel_field(w.pixel_blue, blue_bits);
                end else begin
                    o.pixel_value = {24'b0, nearest[{w.pixel_red[7:5], w.pixel_green[7:5],
                                                     w.pixel_blue[7:6]}]};
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_in_word mk_word(t_action a, logic [7:0] ei, logic [15:0] er,
                                         logic [15:0] eg, logic [15:0] eb, logic [7:0] pr,
                                         logic [7:0] pg, logic [7:0] pb);
        t_in_word w;
        w.action      = a;
        w.entry_index = ei;
        w.entry_red   = er;
        w.entry_green = eg;
        w.entry_blue  = eb;
        w.pixel_red   = pr;
        w.pixel_green = pg;
        w.pixel_blue  = pb;
        return w;
    endfunction

    function automatic t_dir_row item_row(t_in_word w, bit typed, t_out_word want);
        t_dir_row r;
        r.is_reg = 1'b0;
        r.idx    = CFG_MODE;
        r.data   = '0;
        r.word   = w;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic t_dir_row reg_row(t_cfg_idx idx, logic [31:0] data);
        t_dir_row r;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        r.word   = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    // palette colours: exact cube targets, copies of lower entries (ties), rails, noise
    function automatic t_in_word rand_word(t_action a, logic [7:0] slot);
        t_in_word   w;
        logic [7:0] k;
        int         j;
        w = mk_word(a, slot, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                    8'($urandom()), 8'($urandom()), 8'($urandom()));
        if (a == ACT_WRITE) begin
            case ($urandom_range(0, 3))
                0: begin
                    k = 8'($urandom());
                    w.entry_red   = {k[7:5], 13'b0};
                    w.entry_green = {k[4:2], 13'b0};
                    w.entry_blue  = {k[1:0], 14'b0};
                end
                1: if (slot != 0) begin
                    j = $urandom_range(0, int'(slot) - 1);
                    w.entry_red   = pal_red[j];
                    w.entry_green = pal_grn[j];
                    w.entry_blue  = pal_blu[j];
                end
                2: begin
                    w.entry_red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    w.entry_green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    w.entry_blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                default: ;
            endcase
        end
        if ($urandom_range(0, 7) == 0) w.pixel_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0) w.pixel_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0) w.pixel_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return w;
    endfunction

    function automatic logic [31:0] rand_mask(logic [31:0] dflt);
        int          len;
        int          pos;
        logic [63:0] run;
        len = $urandom_range(1, 12);
        pos = $urandom_range(0, 31);
        run = ((64'd1 << len) - 64'd1) << pos;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return dflt;
            3:       return run[31:0];
            4:       return $urandom();
            default: return run[31:0] | (32'h1 << $urandom_range(0, 31));
        endcase
    endfunction

    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        int        gap;
        t_out_word got;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= w;
        do @(posedge i_clk); while (o_busy);
        got = convert_word(w);
        pending_words.push_back(typed ? want : got);
        n_act[w.action]++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_start <= 1'b0;
        while (pending_words.size() != 0 || o_busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:  mode_pal   = data[0];
            CFG_RED:   red_bits   = data;
            CFG_GREEN: green_bits = data;
            default:   blue_bits  = data;
        endcase
        n_regs++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: expected no word, got pixel_value %h is_pixel %b",
                         $time, o_out.pixel_value, o_out.is_pixel);
            end else begin
                mon_want = pending_words.pop_front();
                if (o_out.pixel_value !== mon_want.pixel_value) begin
                    errors++;
                    $display("%0t: pixel_value expected %h, got %h",
                             $time, mon_want.pixel_value, o_out.pixel_value);
                end
                if (o_out.is_pixel !== mon_want.is_pixel) begin
                    errors++;
                    $display("%0t: is_pixel expected %b, got %b",
                             $time, mon_want.is_pixel, o_out.is_pixel);
                end
            end
        end
    end

    initial begin
        t_action act;
        mode_pal   = 1'b0;
        red_bits   = RED_MASK_RST;
        green_bits = GREEN_MASK_RST;
        blue_bits  = BLUE_MASK_RST;
        for (int i = 0; i < 256; i++) begin
            pal_red[i] = '0;
            pal_grn[i] = '0;
            pal_blu[i] = '0;
            nearest[i] = '0;
        end

        // reset masks, then lookups before any build, then odd masks
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                    1, {32'h0000_0000, 1'b1}));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF),
                                    1, {32'h00FF_FFFF, 1'b1}));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'h12, 8'h34, 8'h56),
                                    1, {32'h0012_3456, 1'b1}));
        dir_rows.push_back(item_row(mk_word(ACT_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            8'hFF, 8'hFF, 8'hFF), 1, {32'h0, 1'b0}));
        dir_rows.push_back(item_row(mk_word(ACT_WRITE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            0, 0, 0), 1, {32'h0, 1'b0}));
        dir_rows.push_back(item_row(mk_word(ACT_WRITE, 8'hFF, 16'h0000, 16'h0000, 16'h0000,
                                            8'hFF, 8'hFF, 8'hFF), 1, {32'h0, 1'b0}));
        dir_rows.push_back(reg_row(CFG_MODE, 32'h1));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF),
                                    1, {32'h0, 1'b1}));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                    1, {32'h0, 1'b1}));
        dir_rows.push_back(reg_row(CFG_MODE, 32'h0));
        dir_rows.push_back(reg_row(CFG_RED, 32'h0000_0000));
        dir_rows.push_back(reg_row(CFG_GREEN, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_BLUE, 32'h8000_0000));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF),
                                    1, {32'h8000_00FF, 1'b1}));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'hA5, 8'hC3, 8'h7E),
                                    0, '0));
        dir_rows.push_back(reg_row(CFG_RED, 32'h0000_0F00));
        dir_rows.push_back(reg_row(CFG_GREEN, 32'h00F0_F000));
        dir_rows.push_back(reg_row(CFG_BLUE, 32'h0000_01FF));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF),
                                    0, '0));
        dir_rows.push_back(item_row(mk_word(ACT_CONVERT, 0, 0, 0, 0, 8'h5A, 8'h3C, 8'hC3),
                                    0, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_reg) write_reg(dir_rows[k].idx, dir_rows[k].data);
            else send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
        end

        // whole palette must be written before the first build
        for (int e = 0; e < 256; e++) begin
            no_gaps = (e >= 128);
            send_word(rand_word(ACT_WRITE, 8'(e)), 0, '0);
        end
        send_word(mk_word(ACT_BUILD, 0, 0, 0, 0, 0, 0, 0), 1, {32'h0, 1'b0});

        for (int r = 0; r < 8; r++) begin
            no_gaps = (r % 3 == 2);
            write_reg(CFG_MODE, (r % 2 == 0) ? 32'h1 : 32'h0);
            write_reg(CFG_RED, rand_mask(RED_MASK_RST));
            write_reg(CFG_GREEN, rand_mask(GREEN_MASK_RST));
            write_reg(CFG_BLUE, rand_mask(BLUE_MASK_RST));
            for (int k = 0; k < 30; k++) begin
                if (k == 20 && r % 2 == 0) begin
                    act = ACT_BUILD;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1:    act = ACT_WRITE;
                        2:       act = ACT_NONE;
                        default: act = ACT_CONVERT;
                    endcase
                end
                send_word(rand_word(act, 8'($urandom())), 0, '0);
            end
        end

        i_start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d palette writes, %0d builds, %0d conversions, %0d unused words",
                 n_act[ACT_WRITE], n_act[ACT_BUILD], n_act[ACT_CONVERT], n_act[ACT_NONE]);
        $display("and %0d register writes; %0d results checked.", n_regs, n_results);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // five builds dominate the run time; the timeout allows several times their length
    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
